FILE: rtl/fbl_pkg.sv
`timescale 1ns / 1ps
// fbl_pkg: shared types, codes and defaults for the free block list allocator
// no dependencies

package fbl_pkg;

	localparam int STACK_ENTRIES_DEF = 50;
	localparam int BLOCK_BITS_DEF    = 24;

	localparam int WORD_W      = 24;
	localparam int FUNC_W      = 3;
	localparam int STATUS_W    = 3;
	localparam int INDEX_W     = 6;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 88;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (STATUS_W + WORD_W + 1 + INDEX_W + 2 * WORD_W);
	localparam int CFG_INDEX_W = 1;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC      = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE       = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_COUNT = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_WORD  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_TOTAL = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_BLOCK = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SPILL     = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_DATA_START = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FS_SIZE    = 1'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_CHK,
		S_SPILL_CNT,
		S_SPILL_OUT,
		S_PUSH
	} state_t;

	function automatic logic is_bad(input logic [WORD_W-1:0] b,
		input logic [WORD_W-1:0] ds, input logic [WORD_W-1:0] fs);
		return (b < ds) || (b >= fs);
	endfunction

endpackage

FILE: rtl/free_block_list_allocator_top.sv
`timescale 1ns / 1ps
// free_block_list_allocator_top: in-core free block stack with chained refill and spill
// depends on fbl_pkg
// flow: load, unused codes, bad free, alloc at count zero and free into a partly filled
//   stack are answered from S_IDLE; free into an empty stack passes S_PUSH; alloc passes
//   S_ALLOC_CHK again per skipped entry; a spilling free passes S_SPILL_CNT, S_SPILL_OUT
//   per entry and S_PUSH, STACK_ENTRIES + 2 beats; requests are taken only in S_IDLE
// reset: arst_n clears state, counters and config registers; stack memory is not cleared

module free_block_list_allocator_top #(
	parameter int STACK_ENTRIES = fbl_pkg::STACK_ENTRIES_DEF,
	parameter int BLOCK_BITS    = fbl_pkg::BLOCK_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [fbl_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [fbl_pkg::WORD_W-1:0]        cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// func, block_number, load_value
	input  logic [fbl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// status, result_block, fill_needed, word_index, word_value, free_total
	output logic [fbl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tlast
);

	import fbl_pkg::*;

	localparam int CW = $clog2(STACK_ENTRIES + 1);
	localparam int AW = $clog2(STACK_ENTRIES);
	localparam int SW = (BLOCK_BITS < WORD_W) ? BLOCK_BITS : WORD_W;

	state_t state_q, state_d;

	logic [WORD_W-1:0]   data_start_q, fs_size_q;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [CW-1:0]       lptr_q, lptr_d;
	logic [AW-1:0]       sptr_q, sptr_d;
	logic [WORD_W-1:0]   total_q, total_d;
	logic [SW-1:0]       blk_q;

	logic [SW-1:0]       mem [STACK_ENTRIES];
	logic [SW-1:0]       rd_data_q;
	logic                mem_we, rd_en;
	logic [AW-1:0]       mem_waddr, rd_addr;
	logic [SW-1:0]       mem_wdata;

	logic                out_valid_q, out_last_q, out_fill_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [WORD_W-1:0]   out_block_q, out_value_q, out_total_q;
	logic [INDEX_W-1:0]  out_index_q;

	logic                emit, e_last, e_fill;
	logic [STATUS_W-1:0] e_status;
	logic [WORD_W-1:0]   e_block, e_value;
	logic [INDEX_W-1:0]  e_index;

	logic                out_free, accept;
	logic [FUNC_W-1:0]   in_func;
	logic [SW-1:0]       in_bn;
	logic [WORD_W-1:0]   in_lv, rd_word;

	assign in_func  = s_axis_tdata[2:0];
	assign in_bn    = SW'(s_axis_tdata[26:3]);
	assign in_lv    = s_axis_tdata[50:27];
	assign rd_word  = WORD_W'(rd_data_q);
	assign out_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		lptr_d    = lptr_q;
		sptr_d    = sptr_q;
		total_d   = total_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		emit      = 1'b0;
		e_last    = 1'b1;
		e_fill    = 1'b0;
		e_status  = ST_OK;
		e_block   = '0;
		e_value   = '0;
		e_index   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_func)
						FUNC_ALLOC: begin
							if (cnt_q == '0) begin
								emit     = 1'b1;
								e_status = ST_NO_SPACE;
							end else begin
								cnt_d   = cnt_q - CW'(1);
								rd_en   = 1'b1;
								rd_addr = AW'(cnt_q - CW'(1));
								state_d = S_ALLOC_CHK;
							end
						end
						FUNC_FREE: begin
							if (is_bad(WORD_W'(in_bn), data_start_q, fs_size_q)) begin
								emit     = 1'b1;
								e_status = ST_BAD_BLOCK;
								e_block  = WORD_W'(in_bn);
							end else begin
								if (total_q != '1)
									total_d = total_q + WORD_W'(1);
								if (cnt_q == '0) begin
									mem_we  = 1'b1;
									cnt_d   = CW'(1);
									state_d = S_PUSH;
								end else if (cnt_q >= CW'(STACK_ENTRIES)) begin
									state_d = S_SPILL_CNT;
								end else begin
									mem_we    = 1'b1;
									mem_waddr = AW'(cnt_q);
									mem_wdata = in_bn;
									cnt_d     = cnt_q + CW'(1);
									emit      = 1'b1;
									e_block   = WORD_W'(in_bn);
								end
							end
						end
						FUNC_LOAD_COUNT: begin
							lptr_d = '0;
							emit   = 1'b1;
							if (in_lv >= WORD_W'(1) && in_lv <= WORD_W'(STACK_ENTRIES)) begin
								cnt_d = CW'(in_lv);
							end else begin
								cnt_d    = '0;
								e_status = ST_BAD_COUNT;
							end
						end
						FUNC_LOAD_WORD: begin
							emit = 1'b1;
							if (lptr_q < CW'(STACK_ENTRIES)) begin
								mem_we    = 1'b1;
								mem_waddr = AW'(lptr_q);
								mem_wdata = SW'(in_lv);
								lptr_d    = lptr_q + CW'(1);
							end
						end
						FUNC_LOAD_TOTAL: begin
							total_d = in_lv;
							emit    = 1'b1;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC_CHK: begin
				if (out_free) begin
					if (rd_data_q == '0) begin
						emit     = 1'b1;
						e_status = ST_NO_SPACE;
						state_d  = S_IDLE;
					end else if (is_bad(rd_word, data_start_q, fs_size_q)) begin
						if (cnt_q == '0) begin
							emit     = 1'b1;
							e_status = ST_NO_SPACE;
							state_d  = S_IDLE;
						end else begin
							cnt_d   = cnt_q - CW'(1);
							rd_en   = 1'b1;
							rd_addr = AW'(cnt_q - CW'(1));
						end
					end else begin
						emit    = 1'b1;
						e_block = rd_word;
						e_fill  = (cnt_q == '0);
						if (cnt_q == '0)
							lptr_d = '0;
						if (total_q != '0)
							total_d = total_q - WORD_W'(1);
						state_d = S_IDLE;
					end
				end
			end
			S_SPILL_CNT: begin
				if (out_free) begin
					emit     = 1'b1;
					e_last   = 1'b0;
					e_status = ST_SPILL;
					e_block  = WORD_W'(blk_q);
					e_value  = WORD_W'(cnt_q);
					sptr_d   = '0;
					rd_en    = 1'b1;
					state_d  = S_SPILL_OUT;
				end
			end
			S_SPILL_OUT: begin
				if (out_free) begin
					emit     = 1'b1;
					e_last   = 1'b0;
					e_status = ST_SPILL;
					e_block  = WORD_W'(blk_q);
					e_index  = INDEX_W'(sptr_q) + INDEX_W'(1);
					e_value  = rd_word;
					if (sptr_q == AW'(STACK_ENTRIES - 1)) begin
						cnt_d   = '0;
						state_d = S_PUSH;
					end else begin
						sptr_d  = sptr_q + AW'(1);
						rd_en   = 1'b1;
						rd_addr = sptr_q + AW'(1);
					end
				end
			end
			S_PUSH: begin
				if (out_free) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(cnt_q);
					mem_wdata = blk_q;
					cnt_d     = cnt_q + CW'(1);
					emit      = 1'b1;
					e_block   = WORD_W'(blk_q);
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			data_start_q <= '0;
			fs_size_q    <= '0;
			cnt_q        <= '0;
			lptr_q       <= '0;
			sptr_q       <= '0;
			total_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			lptr_q  <= lptr_d;
			sptr_q  <= sptr_d;
			total_q <= total_d;
			if (cfg_wr_en) begin
				if (cfg_index == REG_DATA_START)
					data_start_q <= cfg_data;
				if (cfg_index == REG_FS_SIZE)
					fs_size_q <= cfg_data;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// result beat and captured block number
	always_ff @(posedge clk) begin
		if (accept)
			blk_q <= in_bn;
		if (emit) begin
			out_status_q <= e_status;
			out_block_q  <= e_block;
			out_fill_q   <= e_fill;
			out_index_q  <= e_index;
			out_value_q  <= e_value;
			out_total_q  <= total_d;
			out_last_q   <= e_last;
		end
	end

	// stack memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_total_q, out_value_q, out_index_q,
		out_fill_q, out_block_q, out_status_q};

endmodule

FILE: sim/free_list_checker.sv
`timescale 1ns / 1ps
// free_list_checker: watches the config port and both streams of the free block list
// allocator, predicts every result beat and compares it field by field; needs fbl_pkg

module free_list_checker #(
	parameter int STACK_ENTRIES = fbl_pkg::STACK_ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [fbl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fbl_pkg::WORD_W-1:0]      cfg_data,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	// func, block_number, load_value
	input  logic [fbl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status, result_block, fill_needed, word_index, word_value, free_total
	input  logic [fbl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            m_axis_tlast,
	output int                              errors,
	output int                              pending
);

	import fbl_pkg::*;

	localparam int BLK_LSB   = STATUS_W;
	localparam int FILL_BIT  = BLK_LSB + WORD_W;
	localparam int IDX_LSB   = FILL_BIT + 1;
	localparam int VAL_LSB   = IDX_LSB + INDEX_W;
	localparam int TOTAL_LSB = VAL_LSB + WORD_W;
	localparam logic [WORD_W-1:0] WORD_MAX = '1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   result_block;
		logic                fill_needed;
		logic [INDEX_W-1:0]  word_index;
		logic [WORD_W-1:0]   word_value;
		logic [WORD_W-1:0]   free_total;
		logic                last;
	} result_beat_t;

	logic [WORD_W-1:0] stack_mem [STACK_ENTRIES];
	int                depth;
	int                load_ptr;
	logic [WORD_W-1:0] total;
	logic [WORD_W-1:0] data_start;
	logic [WORD_W-1:0] fs_size;
	result_beat_t      expected_beats [$];
	result_beat_t      oldest;

	function automatic logic outside_data_area(input logic [WORD_W-1:0] blk);
		return (blk < data_start) || (blk >= fs_size);
	endfunction

	function automatic result_beat_t make_beat(input logic [STATUS_W-1:0] status,
		input logic [WORD_W-1:0] blk, input logic fill, input int idx,
		input logic [WORD_W-1:0] val);
		result_beat_t b;
		b.status       = status;
		b.result_block = blk;
		b.fill_needed  = fill;
		b.word_index   = INDEX_W'(idx);
		b.word_value   = val;
		b.free_total   = '0;
		b.last         = 1'b0;
		return b;
	endfunction

	task automatic predict_step(input logic [FUNC_W-1:0] func,
		input logic [WORD_W-1:0] blk, input logic [WORD_W-1:0] val);
		result_beat_t      beats [$];
		logic [WORD_W-1:0] popped;
		logic              found;
		logic              stop;
		case (func)
			FUNC_ALLOC: begin
				found  = 1'b0;
				stop   = 1'b0;
				popped = '0;
				while (depth > 0 && !stop) begin
					depth--;
					popped = stack_mem[depth];
					if (popped == '0) begin
						stop = 1'b1;
					end else if (!outside_data_area(popped)) begin
						found = 1'b1;
						stop  = 1'b1;
					end
				end
				if (!found) begin
					beats.push_back(make_beat(ST_NO_SPACE, '0, 1'b0, 0, '0));
				end else begin
					if (depth == 0)
						load_ptr = 0;
					if (total != '0)
						total--;
					beats.push_back(make_beat(ST_OK, popped, depth == 0, 0, '0));
				end
			end
			FUNC_FREE: begin
				if (outside_data_area(blk)) begin
					beats.push_back(make_beat(ST_BAD_BLOCK, blk, 1'b0, 0, '0));
				end else begin
					if (depth == 0) begin
						depth        = 1;
						stack_mem[0] = '0;
					end
					if (depth >= STACK_ENTRIES) begin
						beats.push_back(make_beat(ST_SPILL, blk, 1'b0, 0, WORD_W'(depth)));
						for (int i = 0; i < STACK_ENTRIES; i++)
							beats.push_back(make_beat(ST_SPILL, blk, 1'b0, i + 1, stack_mem[i]));
						depth = 0;
					end
					stack_mem[depth] = blk;
					depth++;
					if (total != WORD_MAX)
						total++;
					beats.push_back(make_beat(ST_OK, blk, 1'b0, 0, '0));
				end
			end
			FUNC_LOAD_COUNT: begin
				load_ptr = 0;
				if (val >= 1 && val <= STACK_ENTRIES) begin
					depth = int'(val);
					beats.push_back(make_beat(ST_OK, '0, 1'b0, 0, '0));
				end else begin
					depth = 0;
					beats.push_back(make_beat(ST_BAD_COUNT, '0, 1'b0, 0, '0));
				end
			end
			FUNC_LOAD_WORD: begin
				if (load_ptr < STACK_ENTRIES) begin
					stack_mem[load_ptr] = val;
					load_ptr++;
				end
				beats.push_back(make_beat(ST_OK, '0, 1'b0, 0, '0));
			end
			FUNC_LOAD_TOTAL: begin
				total = val;
				beats.push_back(make_beat(ST_OK, '0, 1'b0, 0, '0));
			end
			default: begin
				beats.push_back(make_beat(ST_OK, '0, 1'b0, 0, '0));
			end
		endcase
		foreach (beats[i]) begin
			beats[i].free_total = total;
			beats[i].last       = (i == beats.size() - 1);
			expected_beats.push_back(beats[i]);
		end
	endtask

	task automatic check_field(input string name, input logic [WORD_W-1:0] want,
		input logic [WORD_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth      = 0;
			load_ptr   = 0;
			total      = '0;
			data_start = '0;
			fs_size    = '0;
			errors     = 0;
			expected_beats.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DATA_START: data_start = cfg_data;
					REG_FS_SIZE:    fs_size    = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_step(s_axis_tdata[0 +: FUNC_W], s_axis_tdata[FUNC_W +: WORD_W],
					s_axis_tdata[FUNC_W + WORD_W +: WORD_W]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_beats.size() == 0) begin
					$error("result beat with nothing expected: tdata %0h", m_axis_tdata);
					errors++;
				end else begin
					oldest = expected_beats.pop_front();
					check_field("status", WORD_W'(oldest.status), WORD_W'(m_axis_tdata[0 +: STATUS_W]));
					check_field("result_block", oldest.result_block,
						m_axis_tdata[BLK_LSB +: WORD_W]);
					check_field("fill_needed", WORD_W'(oldest.fill_needed),
						WORD_W'(m_axis_tdata[FILL_BIT]));
					check_field("word_index", WORD_W'(oldest.word_index),
						WORD_W'(m_axis_tdata[IDX_LSB +: INDEX_W]));
					check_field("word_value", oldest.word_value, m_axis_tdata[VAL_LSB +: WORD_W]);
					check_field("free_total", oldest.free_total, m_axis_tdata[TOTAL_LSB +: WORD_W]);
					check_field("last", WORD_W'(oldest.last), WORD_W'(m_axis_tlast));
				end
			end
			pending <= expected_beats.size();
		end
	end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// testbench: drives directed and random alloc, free, load and unused-code requests into
// free_block_list_allocator_top with random idling; needs fbl_pkg and free_list_checker

module testbench;
	import fbl_pkg::*;

	localparam int STACK_ENTRIES = STACK_ENTRIES_DEF;
	localparam int ITEMS_PER_PHASE = 34;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES = STACK_ENTRIES + 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [WORD_W-1:0] WORD_MAX = '1;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [WORD_W-1:0]      cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// func, block_number, load_value
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// status, result_block, fill_needed, word_index, word_value, free_total
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	int                errors;
	int                pending;
	int                quiet_cycles;
	int                src_idle_pct;
	int                sink_stall_pct;
	logic [WORD_W-1:0] cur_ds;
	logic [WORD_W-1:0] cur_fs;

	free_block_list_allocator_top #(
		.STACK_ENTRIES(STACK_ENTRIES),
		.BLOCK_BITS   (BLOCK_BITS_DEF)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	free_list_checker #(
		.STACK_ENTRIES(STACK_ENTRIES)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("free_block_list_allocator_top test failed");
		$finish;
	end

	task automatic send_request(input logic [FUNC_W-1:0] func, input logic [WORD_W-1:0] blk,
		input logic [WORD_W-1:0] val);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - FUNC_W - 2 * WORD_W){1'b0}}, val, blk, func};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drain(input int extra);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic set_data_range(input logic [WORD_W-1:0] ds, input logic [WORD_W-1:0] fs);
		drain(SETTLE_CYCLES);
		write_reg(REG_DATA_START, ds);
		write_reg(REG_FS_SIZE, fs);
		cfg_wr_en <= 1'b0;
		cur_ds = ds;
		cur_fs = fs;
	endtask

	function automatic logic [WORD_W-1:0] pick_good();
		if (cur_fs > cur_ds)
			return cur_ds + WORD_W'($urandom_range(0, cur_fs - cur_ds - 1));
		return WORD_W'($urandom);
	endfunction

	function automatic logic [WORD_W-1:0] pick_block();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return WORD_W'($urandom);
		return pick_good();
	endfunction

	function automatic logic [WORD_W-1:0] pick_odd_count();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return WORD_W'(STACK_ENTRIES + 1);
			2: return WORD_MAX;
			default: return WORD_W'($urandom);
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] pick_total();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return WORD_W'(1);
			2: return WORD_MAX - 1;
			3: return WORD_MAX;
			default: return WORD_W'($urandom);
		endcase
	endfunction

	task automatic run_random_items(input int count);
		int                sent;
		int                r;
		int                n;
		logic [WORD_W-1:0] c;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				if ($urandom_range(0, 9) < 8)
					c = WORD_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ? STACK_ENTRIES : 8));
				else
					c = pick_odd_count();
				send_request(FUNC_LOAD_COUNT, WORD_W'($urandom), c);
				sent++;
				n = (c >= 1 && c <= STACK_ENTRIES) ? int'(c) : $urandom_range(0, 3);
				if ($urandom_range(0, 7) == 0)
					n += 2;
				repeat (n) begin
					send_request(FUNC_LOAD_WORD, WORD_W'($urandom), pick_block());
					sent++;
				end
			end else if (r < 45) begin
				repeat ($urandom_range(1, 5)) begin
					send_request(FUNC_ALLOC, WORD_W'($urandom), WORD_W'($urandom));
					sent++;
				end
			end else if (r < 70) begin
				repeat ($urandom_range(1, 5)) begin
					send_request(FUNC_FREE, pick_block(), WORD_W'($urandom));
					sent++;
				end
			end else if (r < 78) begin
				// full stack, then a free that spills it
				send_request(FUNC_LOAD_COUNT, WORD_W'($urandom), WORD_W'(STACK_ENTRIES));
				send_request(FUNC_FREE, pick_good(), WORD_W'($urandom));
				sent += 2;
			end else if (r < 84) begin
				send_request(FUNC_LOAD_TOTAL, WORD_W'($urandom), pick_total());
				sent++;
			end else begin
				send_request(FUNC_W'($urandom_range(0, 7)), WORD_W'($urandom), WORD_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		cfg_wr_en      <= 1'b0;
		cfg_index      <= REG_DATA_START;
		cfg_data       <= '0;
		s_axis_tvalid  <= 1'b0;
		s_axis_tdata   <= '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		cur_ds         = '0;
		cur_fs         = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset range makes every block bad
		send_request(FUNC_ALLOC, '0, '0);
		send_request(FUNC_FREE, '0, '0);
		send_request(FUNC_FREE, WORD_MAX, WORD_MAX);
		send_request(FUNC_LOAD_TOTAL, '0, WORD_MAX);
		send_request(FUNC_LOAD_COUNT, '0, '0);
		send_request(FUNC_LOAD_COUNT, '0, WORD_W'(STACK_ENTRIES + 1));
		send_request(FUNC_LOAD_COUNT, WORD_MAX, WORD_MAX);
		send_request(FUNC_UNUSED_LO, WORD_MAX, WORD_MAX);
		send_request(FUNC_UNUSED_HI, 24'h5a5a5a, 24'ha5a5a5);

		set_data_range(WORD_W'(1), WORD_MAX);
		send_request(FUNC_FREE, WORD_MAX - 1, '0);
		send_request(FUNC_FREE, WORD_MAX, '0);
		send_request(FUNC_FREE, '0, '0);
		send_request(FUNC_ALLOC, '0, '0);
		send_request(FUNC_ALLOC, '0, '0);

		// chain load that writes every stack entry, top two entries bad
		send_request(FUNC_LOAD_COUNT, '0, WORD_W'(STACK_ENTRIES));
		for (int i = 0; i < STACK_ENTRIES; i++)
			send_request(FUNC_LOAD_WORD, WORD_W'($urandom),
				(i == 0) ? '0 : (i >= STACK_ENTRIES - 2) ? WORD_MAX : WORD_W'(i) * 24'h2f3 + 1);
		send_request(FUNC_LOAD_WORD, '0, WORD_MAX);
		send_request(FUNC_ALLOC, '0, '0);
		send_request(FUNC_LOAD_COUNT, '0, WORD_W'(STACK_ENTRIES));
		send_request(FUNC_FREE, 24'h800000, '0);
		send_request(FUNC_ALLOC, '0, '0);
		send_request(FUNC_LOAD_TOTAL, '0, '0);
		send_request(FUNC_LOAD_COUNT, '0, WORD_W'(2));
		send_request(FUNC_ALLOC, '0, '0);

		set_data_range(WORD_MAX, WORD_MAX);
		send_request(FUNC_LOAD_COUNT, '0, WORD_W'(4));
		send_request(FUNC_ALLOC, '0, '0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_data_range(WORD_W'(16), WORD_W'(4096));
				1: set_data_range('0, WORD_MAX);
				2: begin
					cur_ds = WORD_W'($urandom_range(1, 2000));
					set_data_range(cur_ds, cur_ds + WORD_W'($urandom_range(2, 3000)));
				end
				default: set_data_range(WORD_W'($urandom_range(0, 24'hffff00)), WORD_MAX);
			endcase
			src_idle_pct   = (phase == 1) ? 72 : (phase == 3) ? 32 : 0;
			sink_stall_pct = (phase == 2) ? 72 : (phase == 3) ? 32 : 0;
			run_random_items(ITEMS_PER_PHASE);
		end

		drain(END_CYCLES);
		if (errors == 0)
			$display("free_block_list_allocator_top test passed");
		else
			$display("free_block_list_allocator_top test failed");
		$finish;
	end

endmodule
